// ----- hw/rtl/wss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics package
// Payload structs, controller/datapath command and status types, constants.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int COUNT_BITS  = 32;
  localparam logic [31:0] PERIOD_RESET = 32'd1000000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_REFRESH = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [63:0] scaled_count;
    logic [31:0] mean;
    logic [63:0] variance;
    logic [31:0] low_mark;
    logic [31:0] high_mark;
    logic [31:0] elapsed_ticks;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accum;      // apply the input item to the running values
    logic snap;       // capture running values into report regs, clear running
    logic div_start;  // start one division
    logic [1:0] div_sel;  // which quotient
    logic var_mul;    // square the mean
    logic var_sub;    // form variance
    logic mul_start;  // count * ticks partial products
    logic load_out;   // move the finished report into the output register
  } dp_cmd_t;

  typedef enum logic [1:0] {
    DIV_MEAN  = 2'd0,
    DIV_SQ    = 2'd1,
    DIV_SCALE = 2'd2
  } div_sel_t;

  // Datapath -> controller status
  typedef struct packed {
    logic report_due;  // after accumulation, period reached
    logic div_done;
    logic mul_done;
    logic has_samples; // snapshot holds at least one sample
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/windowed_sample_statistics.sv -----
// After an item without a report, the next item is accepted the next cycle. A report
// is computed after its input transfer: snapshot, mean and square-sum divisions
// (skipped with no samples), variance steps, count-by-ticks product, scaling division;
// all divisions share one divider. Throughput: one item per cycle between reports;
// input stalls while a report is computed and while it waits on a full output register.
// Reset (rst, synchronous) clears running values and sets target_period to 1000000.
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics
// Running count, sums, marks and period ticks with periodic reports.
// ----------------------------------------------------------------------------
module windowed_sample_statistics (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wss_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wss_pkg::out_item_t       out_data
);
  import wss_pkg::*;

  logic [31:0] target_period;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Period register
  always_ff @(posedge clk) begin
    if (rst) target_period <= PERIOD_RESET;
    else if (cfg_we) target_period <= cfg_data;
  end

  wss_control u_ctl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item        (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  wss_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_period (target_period),
    .item       (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_item   (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/wss_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics divider
// Radix-2 restoring divider, 64-bit dividend by 64-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
module wss_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  import wss_pkg::*;

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem, quo[63]};
  assign trial   = shifted - {1'b0, dvs};
  assign quotient = quo;

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wss_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics datapath
// Running accumulators, report snapshot, shared divider and multipliers.
// ----------------------------------------------------------------------------
module wss_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [31:0]        cfg_period,
  input  wire wss_pkg::in_item_t  item,
  input  wire wss_pkg::dp_cmd_t   cmd,
  output wss_pkg::dp_sts_t        sts,
  output wss_pkg::out_item_t      out_item
);
  import wss_pkg::*;

  logic [COUNT_BITS-1:0] sample_count;
  logic [63:0] sample_sum;
  logic [63:0] square_sum;
  logic [31:0] running_low;
  logic [31:0] running_high;
  logic [31:0] period_ticks;

  // Snapshot used while the report is computed
  logic [COUNT_BITS-1:0] snap_count;
  logic [63:0] snap_sum;
  logic [63:0] snap_sq;
  logic [31:0] snap_ticks;
  logic [31:0] tp_eff;

  out_item_t   report;
  logic [31:0] s;
  logic [63:0] s_sq;
  logic [31:0] ticks_inc;
  logic [31:0] mean_sat;
  logic [63:0] mean_sq;
  logic [63:0] sq_quot;

  // Count * ticks split into two 32x16 partial products
  logic [47:0] pp_lo;
  logic [47:0] pp_hi;
  logic [1:0]  mul_phase;

  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic [63:0] prod;

  assign s    = item.sample & (32'hFFFF_FFFF >> (32 - SAMPLE_BITS));
  assign s_sq = 64'(s) * 64'(s);
  assign ticks_inc = (period_ticks != 32'hFFFF_FFFF) ? period_ticks + 32'd1 : period_ticks;
  assign tp_eff = (cfg_period == 32'd0) ? 32'd1 : cfg_period;

  // Report due check uses the value the tick would leave
  always_comb begin
    sts.report_due = 1'b0;
    if (item.kind == KIND_TICK) sts.report_due = (ticks_inc >= tp_eff);
    else sts.report_due = (period_ticks >= tp_eff);
    sts.div_done = div_done;
    sts.mul_done = (mul_phase == 2'd2);
    sts.has_samples = (snap_count != '0);
  end

  // Running accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.snap || (cmd.accum && item.kind == KIND_CLEAR)) begin
      sample_count <= '0;
      sample_sum   <= '0;
      square_sum   <= '0;
      running_low  <= '1;
      running_high <= '0;
      period_ticks <= '0;
    end else if (cmd.accum) begin
      if (item.kind == KIND_SAMPLE) begin
        if (sample_count != COUNT_MAX) sample_count <= sample_count + 1'b1;
        sample_sum <= sample_sum + 64'(s);
        square_sum <= square_sum + s_sq;
        if (s < running_low)  running_low  <= s;
        if (s > running_high) running_high <= s;
      end else if (item.kind == KIND_TICK) begin
        period_ticks <= ticks_inc;
      end
    end
  end

  // Snapshot and report registers
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_count <= sample_count;
      snap_sum   <= sample_sum;
      snap_sq    <= square_sum;
      snap_ticks <= period_ticks;
      report.low_mark      <= (sample_count != '0) ? running_low : 32'd0;
      report.high_mark     <= running_high;
      report.elapsed_ticks <= period_ticks;
      report.mean          <= '0;
      report.variance      <= '0;
      sq_quot              <= '0;
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_MEAN: report.mean <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
        DIV_SQ: sq_quot <= div_q;
        DIV_SCALE: report.scaled_count <= div_q;
        default: ;
      endcase
    end
    if (cmd.var_mul) mean_sq <= 64'(mean_sat) * 64'(mean_sat);
    if (cmd.var_sub) report.variance <= sq_quot - mean_sq;
  end

  assign mean_sat = report.mean;

  // Output register, frees the report registers for the next period
  always_ff @(posedge clk) begin
    if (cmd.load_out) out_item <= report;
  end

  // Two-step product of count and ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_phase <= '0;
    end else if (cmd.mul_start) begin
      mul_phase <= 2'd1;
      pp_lo <= 48'(snap_count) * 48'(snap_ticks[15:0]);
      pp_hi <= 48'(snap_count) * 48'(snap_ticks[31:16]);
    end else if (mul_phase == 2'd1) begin
      mul_phase <= 2'd2;
      prod <= 64'(pp_lo) + (64'(pp_hi) << 16);
    end else begin
      mul_phase <= '0;
    end
  end

  // Divider operand selection
  always_comb begin
    div_start = cmd.div_start;
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_a = snap_sum;
        div_b = 64'(snap_count);
      end
      DIV_SQ: begin
        div_a = snap_sq;
        div_b = 64'(snap_count);
      end
      DIV_SCALE: begin
        div_a = prod;
        div_b = 64'(tp_eff);
      end
      default: begin
        div_a = '0;
        div_b = 64'd1;
      end
    endcase
  end

  wss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/wss_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics controller
// Sequences accumulation, report snapshot, divisions and output transfer.
// ----------------------------------------------------------------------------
module wss_control (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wss_pkg::in_item_t item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wss_pkg::dp_cmd_t      cmd,
  input  wire wss_pkg::dp_sts_t sts
);
  import wss_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SNAP   = 10'b0000000010,
    ST_MEAN   = 10'b0000000100,
    ST_SQ_GO  = 10'b0000001000,
    ST_SQ     = 10'b0000010000,
    ST_VMUL   = 10'b0000100000,
    ST_VSUB   = 10'b0001000000,
    ST_MUL    = 10'b0010000000,
    ST_SCALE  = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] sel, sel_next;
  logic accepted;
  logic out_full;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;
  assign accepted  = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    cmd           = '0;
    cmd.div_sel   = sel;
    case (state)
      ST_IDLE: begin
        if (accepted) begin
          cmd.accum = (item.kind != KIND_REFRESH);
          if (item.kind == KIND_REFRESH ||
              (item.kind != KIND_CLEAR && sts.report_due)) state_next = ST_SNAP;
        end
      end
      ST_SNAP: begin
        cmd.snap = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        if (sts.has_samples) begin
          sel_next = DIV_MEAN;
          cmd.div_sel = DIV_MEAN;
          cmd.div_start = 1'b1;
          state_next = ST_SQ_GO;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SQ_GO: begin
        if (sts.div_done) begin
          sel_next = DIV_SQ;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.div_start = 1'b1;
        state_next = ST_VMUL;
      end
      ST_VMUL: begin
        if (sts.div_done) begin
          cmd.var_mul = 1'b1;
          state_next = ST_VSUB;
        end
      end
      ST_VSUB: begin
        cmd.var_sub = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_start = 1'b1;
        sel_next = DIV_SCALE;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (sts.mul_done) cmd.div_start = 1'b1;
        if (sts.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        // Hand the report to the output register once it is free
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= DIV_MEAN;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_out) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- bench/windowed_sample_statistics_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed sample statistics testbench
// Drives samples, ticks, refreshes and clears through the valid/ready input,
// predicts every period report and compares it field by field with the
// block's output, under random idling on both sides and several periods.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_tb;
  import wss_pkg::*;

  // Running statistics predictor and queue of pending reports
  class report_board;
    logic [31:0] period_len;
    logic [31:0] n_samples;
    logic [63:0] sum_acc;
    logic [63:0] sq_acc;
    logic [31:0] lo_acc;
    logic [31:0] hi_acc;
    logic [31:0] ticks_acc;
    out_item_t   pending_reports[$];
    int          errors;

    function new();
      period_len = PERIOD_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      n_samples = '0;
      sum_acc = '0;
      sq_acc = '0;
      lo_acc = '1;
      hi_acc = '0;
      ticks_acc = '0;
    endfunction

    function void emit_report();
      out_item_t   r;
      logic [63:0] n;
      logic [63:0] tp;
      logic [63:0] avg;
      n = {32'd0, n_samples};
      tp = (period_len == 0) ? 64'd1 : {32'd0, period_len};
      avg = '0;
      r = '0;
      if (n != 0) begin
        avg = sum_acc / n;
        if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
        r.variance = sq_acc / n - avg * avg;
      end
      r.scaled_count = (n * {32'd0, ticks_acc}) / tp;
      r.mean = avg[31:0];
      r.low_mark = (n != 0) ? lo_acc : 32'd0;
      r.high_mark = hi_acc;
      r.elapsed_ticks = ticks_acc;
      pending_reports.insert(pending_reports.size(), r);
      restart();
    endfunction

    // Note one accepted input transfer
    function void note_input(in_item_t it);
      logic [31:0] tp;
      logic [31:0] s;
      tp = (period_len == 0) ? 32'd1 : period_len;
      s = it.sample;
      case (kind_t'(it.kind))
        KIND_SAMPLE: begin
          if (n_samples != 32'hFFFF_FFFF) n_samples++;
          sum_acc += {32'd0, s};
          sq_acc += {32'd0, s} * {32'd0, s};
          if (s < lo_acc) lo_acc = s;
          if (s > hi_acc) hi_acc = s;
        end
        KIND_TICK: begin
          if (ticks_acc != 32'hFFFF_FFFF) ticks_acc++;
        end
        KIND_REFRESH: begin
          emit_report();
          return;
        end
        default: begin
          restart();
          return;
        end
      endcase
      if (ticks_acc >= tp) emit_report();
    endfunction

    // Check one output transfer against the oldest pending report
    function void check_report(out_item_t got);
      out_item_t w;
      if (pending_reports.size() == 0) begin
        $error("unexpected report %h", got);
        errors++;
        return;
      end
      w = pending_reports.pop_front();
      if (got.scaled_count !== w.scaled_count) begin
        $error("scaled_count exp %0d got %0d", w.scaled_count, got.scaled_count);
        errors++;
      end
      if (got.mean !== w.mean) begin
        $error("mean exp %0d got %0d", w.mean, got.mean);
        errors++;
      end
      if (got.variance !== w.variance) begin
        $error("variance exp %0d got %0d", w.variance, got.variance);
        errors++;
      end
      if (got.low_mark !== w.low_mark) begin
        $error("low_mark exp %0d got %0d", w.low_mark, got.low_mark);
        errors++;
      end
      if (got.high_mark !== w.high_mark) begin
        $error("high_mark exp %0d got %0d", w.high_mark, got.high_mark);
        errors++;
      end
      if (got.elapsed_ticks !== w.elapsed_ticks) begin
        $error("elapsed_ticks exp %0d got %0d", w.elapsed_ticks, got.elapsed_ticks);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;
  localparam int REPORT_CYCLES = 260;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  report_board board;
  bit          calm_phase;
  bit          hold_receiver;
  int          quiet_cycles;

  windowed_sample_statistics dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scoreboard hooks and watchdog, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_report(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // One input transfer, with an optional idle burst first
  task automatic send_item(kind_t k, logic [31:0] s);
    int n;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, sample: s};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (REPORT_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.period_len = v;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Random well-formed periods: samples and ticks, occasional refresh/clear
  task automatic random_items(int count, int tick_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) send_item(KIND_TICK, $urandom);
      else if (r < 96) send_item(KIND_SAMPLE, rand_sample());
      else if (r < 98) send_item(KIND_REFRESH, $urandom);
      else send_item(KIND_CLEAR, $urandom);
    end
  endtask

  initial begin
    board = new();
    calm_phase = 1'b0;
    hold_receiver = 1'b0;
    quiet_cycles = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: refresh with no samples, extremes, clear, default period
    send_item(KIND_REFRESH, 32'd0);
    send_item(KIND_SAMPLE, 32'hFFFF_FFFF);
    send_item(KIND_SAMPLE, 32'd0);
    send_item(KIND_SAMPLE, 32'hAAAA_5555);
    send_item(KIND_TICK, 32'd0);
    send_item(KIND_REFRESH, 32'hFFFF_FFFF);
    send_item(KIND_SAMPLE, 32'd7);
    send_item(KIND_TICK, 32'd0);
    send_item(KIND_CLEAR, 32'h5555_AAAA);
    send_item(KIND_REFRESH, 32'd0);
    drain_and_idle();

    // Zero period acts as one: every tick reports
    write_period(32'd0);
    send_item(KIND_SAMPLE, 32'd3);
    send_item(KIND_TICK, 32'd0);
    send_item(KIND_TICK, 32'd0);
    drain_and_idle();

    // Lowering the period below elapsed ticks: next sample reports
    write_period(32'd10);
    repeat (5) send_item(KIND_TICK, 32'd0);
    send_item(KIND_SAMPLE, 32'd100);
    drain_and_idle();
    write_period(32'd3);
    send_item(KIND_SAMPLE, 32'd9);
    drain_and_idle();

    // Largest period, then a refresh reports the partial period
    write_period(32'hFFFF_FFFF);
    repeat (3) send_item(KIND_TICK, 32'd0);
    send_item(KIND_SAMPLE, 32'hFFFF_FFFF);
    send_item(KIND_REFRESH, 32'd0);
    drain_and_idle();

    // Random part under short periods; receiver holds off once
    write_period(32'd4);
    hold_receiver = 1'b1;
    random_items(300, 20);
    drain_and_idle();
    write_period(32'd1);
    random_items(200, 25);
    drain_and_idle();
    write_period(32'($urandom_range(5, 40)));
    random_items(400, 15);
    drain_and_idle();

    // Last part: no idling on either side
    calm_phase = 1'b1;
    write_period(32'd6);
    random_items(250, 20);
    drain_and_idle();

    if (board.errors == 0 && board.pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
